>>> design/prcs_pkg.sv
// Shared types, codes and helpers for the prefix run collision statistics block.
`default_nettype none
package prcs_pkg;

	localparam int HIST_BINS_DEF   = 64;
	localparam int PREFIX_BITS_DEF = 40;

	localparam int CNT_W     = 48;
	localparam int PAIR_W    = 64;
	localparam int SIZE_W    = 32;
	localparam int PFX_W     = 40;
	localparam int TAG_W     = 8;
	localparam int LEN_W     = 8;
	localparam int BIN_W     = 6;
	localparam int REQ_W     = 2;
	localparam int STAT_W    = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 8;

	localparam logic [REQ_W-1:0] REQ_KEY  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_END  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

	localparam logic [STAT_W-1:0] STAT_TOTALS = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_BIN    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_TAG = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN = 1'd1;

	localparam logic [TAG_W-1:0] ROW_TAG_RST = 8'd120;
	localparam logic [LEN_W-1:0] KEY_LEN_RST = 8'd12;

	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic [TAG_W-1:0] key_tag;
		logic [PFX_W-1:0] hash_prefix;
		logic [LEN_W-1:0] key_length;
		logic [BIN_W-1:0] bin_index;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [CNT_W-1:0]  row_count;
		logic [CNT_W-1:0]  bad_row_count;
		logic [CNT_W-1:0]  bucket_count;
		logic [CNT_W-1:0]  multi_bucket_count;
		logic [CNT_W-1:0]  surplus_rows;
		logic [PAIR_W-1:0] pair_count;
		logic [SIZE_W-1:0] max_bucket;
		logic [CNT_W-1:0]  bin_count;
	} rsp_t;

	typedef struct packed {
		logic valid;
		logic has_rsp;
		logic is_bin;
		logic close;
	} stage_t;

	function automatic logic [CNT_W-1:0] sat_add_cnt(input logic [CNT_W-1:0] a,
			input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
	endfunction

	function automatic logic [PAIR_W-1:0] sat_add_pair(input logic [PAIR_W-1:0] a,
			input logic [PAIR_W-1:0] b);
		logic [PAIR_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[PAIR_W] ? {PAIR_W{1'b1}} : s[PAIR_W-1:0];
	endfunction

endpackage
`default_nettype wire

>>> design/prcs_hist.sv
// Size histogram memory with read-modify-write, forwarding and reset clearing pass.
`default_nettype none
module prcs_hist #(
	parameter int HIST_BINS = prcs_pkg::HIST_BINS_DEF,
	parameter int AW        = $clog2(HIST_BINS)
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     rd_en,
	input  wire logic [AW-1:0]            rd_addr,
	input  wire logic                     upd,
	output logic                          clearing,
	output logic [prcs_pkg::CNT_W-1:0]    count
);
	import prcs_pkg::*;

	logic [CNT_W-1:0] mem [HIST_BINS];
	logic [CNT_W-1:0] rd_q;
	logic [AW-1:0]    addr_s1;
	logic             clr_q;
	logic [AW-1:0]    clr_addr_q;
	logic             wr_valid_q;
	logic [AW-1:0]    wr_addr_q;
	logic [CNT_W-1:0] wr_data_q;
	logic             fwd;
	logic [CNT_W-1:0] inc;
	logic             we;
	logic [AW-1:0]    wa;
	logic [CNT_W-1:0] wd;

	assign fwd      = wr_valid_q && (wr_addr_q == addr_s1);
	assign count    = fwd ? wr_data_q : rd_q;
	assign inc      = sat_add_cnt(count, CNT_W'(1));
	assign clearing = clr_q;
	assign we       = clr_q || upd;
	assign wa       = clr_q ? clr_addr_q : addr_s1;
	assign wd       = clr_q ? '0 : inc;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end else if (fwd) begin
			rd_q <= wr_data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			addr_s1 <= rd_addr;
		end
		if (upd) begin
			wr_addr_q <= addr_s1;
			wr_data_q <= inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
			wr_valid_q <= 1'b0;
		end else begin
			wr_valid_q <= upd && !clr_q;
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + AW'(1);
				if (clr_addr_q == AW'(HIST_BINS - 1)) begin
					clr_q <= 1'b0;
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_no_upd_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !upd && !rd_en) else $error("histogram access during clearing pass");
	a_clear_len: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clr_q) |-> $past(clr_addr_q) == AW'(HIST_BINS - 1))
		else $error("clearing pass ended early");
`endif

endmodule
`default_nettype wire

>>> design/prcs_tally.sv
// Bucket tracking, scalar counters, configuration registers and stage one control.
`default_nettype none
module prcs_tally #(
	parameter int HIST_BINS   = prcs_pkg::HIST_BINS_DEF,
	parameter int PREFIX_BITS = prcs_pkg::PREFIX_BITS_DEF,
	parameter int AW          = $clog2(HIST_BINS)
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [prcs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [prcs_pkg::CFG_W-1:0]        cfg_data,
	input  wire logic                              acc,
	input  wire prcs_pkg::req_t                    req,
	input  wire logic                              adv,
	output logic [AW-1:0]                          hist_addr,
	output prcs_pkg::stage_t                       stage,
	output prcs_pkg::rsp_t                         totals
);
	import prcs_pkg::*;

	localparam int CMP_W = (PREFIX_BITS < PFX_W) ? PREFIX_BITS : PFX_W;
	localparam logic [SIZE_W-1:0] LAST_BIN = SIZE_W'(HIST_BINS - 1);

	logic [TAG_W-1:0]  row_tag_q;
	logic [LEN_W-1:0]  key_len_q;
	logic [CMP_W-1:0]  open_prefix_q, open_prefix_d;
	logic [SIZE_W-1:0] open_size_q, open_size_d;
	logic              have_open_q, have_open_d;
	logic              scan_over_q, scan_over_d;
	logic [CNT_W-1:0]  row_total_q, row_total_d;
	logic [CNT_W-1:0]  mal_total_q, mal_total_d;
	logic [CNT_W-1:0]  bkt_total_q, bkt_total_d;
	logic [CNT_W-1:0]  col_total_q, col_total_d;
	logic [CNT_W-1:0]  extra_total_q, extra_total_d;
	logic [SIZE_W-1:0] largest_q, largest_d;
	logic [PAIR_W-1:0] pair_total_q, pair_next;
	logic              do_close, do_report, do_read, close_live, multi;
	logic [CMP_W-1:0]  pfx_in;
	logic [PAIR_W-1:0] prod_c;
	logic [AW-1:0]     bin_addr, close_addr;
	logic              valid_s1, has_rsp_s1, is_bin_s1, close_s1, multi_s1;
	logic [PAIR_W-1:0] prod_s1;

	assign pfx_in = req.hash_prefix[CMP_W-1:0];
	assign prod_c = PAIR_W'(open_size_q) * PAIR_W'(open_size_q - SIZE_W'(1));

	assign bin_addr   = (SIZE_W'(req.bin_index) >= LAST_BIN) ? AW'(HIST_BINS - 1)
		: AW'(req.bin_index);
	assign close_addr = (open_size_q >= LAST_BIN) ? AW'(HIST_BINS - 1) : AW'(open_size_q);
	assign hist_addr  = do_read ? bin_addr : close_addr;

	always_comb begin
		open_prefix_d = open_prefix_q;
		open_size_d   = open_size_q;
		have_open_d   = have_open_q;
		scan_over_d   = scan_over_q;
		row_total_d   = row_total_q;
		mal_total_d   = mal_total_q;
		bkt_total_d   = bkt_total_q;
		col_total_d   = col_total_q;
		extra_total_d = extra_total_q;
		largest_d     = largest_q;
		do_close      = 1'b0;
		do_report     = 1'b0;
		do_read       = 1'b0;
		if (acc) begin
			unique case (req.req_type)
				REQ_READ: do_read = 1'b1;
				REQ_END:  do_report = 1'b1;
				REQ_KEY: begin
					if (!scan_over_q) begin
						if (req.key_tag != row_tag_q) begin
							do_report = 1'b1;
						end else if (req.key_length != key_len_q) begin
							mal_total_d = sat_add_cnt(mal_total_q, CNT_W'(1));
						end else begin
							if (!have_open_q || pfx_in != open_prefix_q) begin
								do_close      = 1'b1;
								open_prefix_d = pfx_in;
								have_open_d   = 1'b1;
								open_size_d   = SIZE_W'(1);
							end else if (open_size_q != '1) begin
								open_size_d = open_size_q + SIZE_W'(1);
							end
							row_total_d = sat_add_cnt(row_total_q, CNT_W'(1));
						end
					end
				end
				default: ;
			endcase
		end
		if (do_report) begin
			do_close    = 1'b1;
			scan_over_d = 1'b1;
			open_size_d = '0;
			have_open_d = 1'b0;
		end
		close_live = do_close && (open_size_q != '0);
		multi      = do_close && (open_size_q > SIZE_W'(1));
		if (close_live) begin
			bkt_total_d = sat_add_cnt(bkt_total_q, CNT_W'(1));
			if (open_size_q > largest_q) begin
				largest_d = open_size_q;
			end
		end
		if (multi) begin
			col_total_d   = sat_add_cnt(col_total_q, CNT_W'(1));
			extra_total_d = sat_add_cnt(extra_total_q, CNT_W'(open_size_q - SIZE_W'(1)));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_tag_q     <= ROW_TAG_RST;
			key_len_q     <= KEY_LEN_RST;
			open_prefix_q <= '0;
			open_size_q   <= '0;
			have_open_q   <= 1'b0;
			scan_over_q   <= 1'b0;
			row_total_q   <= '0;
			mal_total_q   <= '0;
			bkt_total_q   <= '0;
			col_total_q   <= '0;
			extra_total_q <= '0;
			largest_q     <= '0;
			pair_total_q  <= '0;
			valid_s1      <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ROW_TAG: row_tag_q <= cfg_data;
					REG_KEY_LEN: key_len_q <= cfg_data;
				endcase
			end
			open_prefix_q <= open_prefix_d;
			open_size_q   <= open_size_d;
			have_open_q   <= have_open_d;
			scan_over_q   <= scan_over_d;
			row_total_q   <= row_total_d;
			mal_total_q   <= mal_total_d;
			bkt_total_q   <= bkt_total_d;
			col_total_q   <= col_total_d;
			extra_total_q <= extra_total_d;
			largest_q     <= largest_d;
			if (adv) begin
				pair_total_q <= pair_next;
			end
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			has_rsp_s1 <= do_read || do_report;
			is_bin_s1  <= do_read;
			close_s1   <= close_live;
			multi_s1   <= multi;
			prod_s1    <= prod_c;
		end
	end

	assign pair_next = (valid_s1 && multi_s1)
		? sat_add_pair(pair_total_q, {1'b0, prod_s1[PAIR_W-1:1]}) : pair_total_q;

	assign stage = '{valid: valid_s1, has_rsp: has_rsp_s1, is_bin: is_bin_s1, close: close_s1};

	always_comb begin
		totals                    = '0;
		totals.status             = (row_total_q == '0) ? STAT_EMPTY : STAT_TOTALS;
		totals.row_count          = row_total_q;
		totals.bad_row_count      = mal_total_q;
		totals.bucket_count       = bkt_total_q;
		totals.multi_bucket_count = col_total_q;
		totals.surplus_rows       = extra_total_q;
		totals.pair_count         = pair_next;
		totals.max_bucket         = largest_q;
	end

`ifndef SYNTHESIS
	a_open_size: assert property (@(posedge clk) disable iff (!arst_n)
		have_open_q == (open_size_q != '0)) else $error("open bucket flag and size disagree");
	a_rows_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req.req_type == REQ_KEY && scan_over_q) |=> $stable(row_total_q))
		else $error("row counted after scan end");
`endif

endmodule
`default_nettype wire

>>> design/prefix_run_collision_stats.sv
// Top level of the prefix run collision statistics block.
`default_nettype none
// Takes one request per cycle while req_ready is high: sorted key rows, end of scan,
// or histogram bin reads. A request is accepted into stage one, where the bucket
// bookkeeping has already been applied and the histogram bin has been read from the
// one-port-read memory; the bin is incremented and written back as the request leaves
// stage one, with the last write forwarded to the next read of the same bin. The
// colliding pair product is registered in stage one and summed as the request leaves.
// A result is written to the output register as its request leaves stage one, and the
// block keeps accepting while a result waits unless stage one also holds a result.
// After reset a clearing pass zeroes the histogram, with req_ready low; configuration
// writes are taken during it.
module prefix_run_collision_stats #(
	parameter int HIST_BINS   = prcs_pkg::HIST_BINS_DEF,
	parameter int PREFIX_BITS = prcs_pkg::PREFIX_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [prcs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [prcs_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                           req_valid,
	output logic                                req_ready,
	input  wire prcs_pkg::req_t                 req,
	output logic                                rsp_valid,
	input  wire logic                           rsp_ready,
	output prcs_pkg::rsp_t                      rsp
);
	import prcs_pkg::*;

	localparam int AW = $clog2(HIST_BINS);

	logic             acc;
	logic             adv;
	logic             upd;
	logic             clearing;
	logic [AW-1:0]    hist_addr;
	logic [CNT_W-1:0] count;
	stage_t           stage;
	rsp_t             totals;
	rsp_t             bin_rsp;
	logic             out_valid_q;
	rsp_t             out_rsp_q;

	assign adv       = stage.valid && (!stage.has_rsp || !out_valid_q || rsp_ready);
	assign req_ready = !clearing && (!stage.valid || adv);
	assign acc       = req_valid && req_ready;
	assign upd       = adv && stage.close;

	prcs_tally #(
		.HIST_BINS  (HIST_BINS),
		.PREFIX_BITS(PREFIX_BITS),
		.AW         (AW)
	) u_tally (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.acc      (acc),
		.req      (req),
		.adv      (adv),
		.hist_addr(hist_addr),
		.stage    (stage),
		.totals   (totals)
	);

	prcs_hist #(
		.HIST_BINS(HIST_BINS),
		.AW       (AW)
	) u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (acc),
		.rd_addr (hist_addr),
		.upd     (upd),
		.clearing(clearing),
		.count   (count)
	);

	always_comb begin
		bin_rsp           = '0;
		bin_rsp.status    = STAT_BIN;
		bin_rsp.bin_count = count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && stage.has_rsp) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && stage.has_rsp) begin
			out_rsp_q <= stage.is_bin ? bin_rsp : totals;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_rsp_q;

`ifndef SYNTHESIS
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(stage.valid && stage.has_rsp && out_valid_q && !rsp_ready) |-> !req_ready)
		else $error("request accepted while stage one is blocked");
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !req_ready && !stage.valid) else $error("request taken during clearing");
`endif

endmodule
`default_nettype wire

>>> test/prefix_run_collision_stats_test.sv
// Self-checking testbench for prefix_run_collision_stats: predicts every totals report and bin read.
module prefix_run_collision_stats_test;
	timeunit 1ns;
	timeprecision 1ps;
	import prcs_pkg::*;

	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int LAST_BIN = HIST_BINS_DEF - 1;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam logic [PAIR_W-1:0] PAIR_MAX = '1;

	class collision_tally;
		rsp_t awaited[$];
		logic [TAG_W-1:0] tag_reg;
		logic [LEN_W-1:0] len_reg;
		logic [PFX_W-1:0] run_prefix;
		logic [SIZE_W-1:0] run_size;
		bit run_open;
		bit scan_done;
		logic [CNT_W-1:0] rows, malformed, buckets, collide_buckets, extra;
		logic [PAIR_W-1:0] pairs;
		logic [SIZE_W-1:0] largest;
		logic [CNT_W-1:0] size_hist [HIST_BINS_DEF];
		int errors, checked, bin_reads, reports;

		function new();
			tag_reg = ROW_TAG_RST;
			len_reg = KEY_LEN_RST;
			run_prefix = '0;
			run_size = '0;
			run_open = 0;
			scan_done = 0;
			rows = '0;
			malformed = '0;
			buckets = '0;
			collide_buckets = '0;
			extra = '0;
			pairs = '0;
			largest = '0;
			foreach (size_hist[i]) size_hist[i] = '0;
			errors = 0;
			checked = 0;
			bin_reads = 0;
			reports = 0;
		endfunction

		function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
			if (idx == REG_ROW_TAG) tag_reg = val;
			else if (idx == REG_KEY_LEN) len_reg = val;
		endfunction

		function logic [CNT_W-1:0] add_cnt(input logic [CNT_W-1:0] a, input logic [CNT_W-1:0] b);
			return (b > CNT_MAX - a) ? CNT_MAX : a + b;
		endfunction

		function logic [PAIR_W-1:0] add_pair(input logic [PAIR_W-1:0] a,
				input logic [PAIR_W-1:0] b);
			return (b > PAIR_MAX - a) ? PAIR_MAX : a + b;
		endfunction

		function void close_run();
			logic [PAIR_W-1:0] n;
			int slot;
			n = run_size;
			if (n != 0) begin
				slot = (n >= LAST_BIN) ? LAST_BIN : int'(n);
				size_hist[slot] = add_cnt(size_hist[slot], CNT_W'(1));
				buckets = add_cnt(buckets, CNT_W'(1));
				if (n > 1) begin
					collide_buckets = add_cnt(collide_buckets, CNT_W'(1));
					extra = add_cnt(extra, CNT_W'(n - 1));
					pairs = add_pair(pairs, (n * (n - 1)) >> 1);
				end
				if (run_size > largest) largest = run_size;
			end
			run_size = '0;
			run_open = 0;
		endfunction

		function rsp_t report();
			rsp_t r;
			close_run();
			scan_done = 1;
			r = '0;
			r.status = (rows == 0) ? STAT_EMPTY : STAT_TOTALS;
			r.row_count = rows;
			r.bad_row_count = malformed;
			r.bucket_count = buckets;
			r.multi_bucket_count = collide_buckets;
			r.surplus_rows = extra;
			r.pair_count = pairs;
			r.max_bucket = largest;
			reports++;
			return r;
		endfunction

		function void take_request(input req_t q);
			rsp_t r;
			int slot;
			case (q.req_type)
				REQ_READ: begin
					slot = (q.bin_index > LAST_BIN) ? LAST_BIN : int'(q.bin_index);
					r = '0;
					r.status = STAT_BIN;
					r.bin_count = size_hist[slot];
					awaited.push_back(r);
					bin_reads++;
				end
				REQ_END: awaited.push_back(report());
				REQ_KEY: if (!scan_done) begin
					if (q.key_tag != tag_reg) begin
						awaited.push_back(report());
					end else if (q.key_length != len_reg) begin
						malformed = add_cnt(malformed, CNT_W'(1));
					end else begin
						if (!run_open || q.hash_prefix != run_prefix) begin
							close_run();
							run_prefix = q.hash_prefix;
							run_open = 1;
						end
						if (run_size != '1) run_size++;
						rows = add_cnt(rows, CNT_W'(1));
					end
				end
				default: ;
			endcase
		endfunction

		function void cmp(input string what, input logic [63:0] want, input logic [63:0] got);
			if (got !== want) begin
				if (errors < 40)
					$display("%0t mismatch in %s: expected %0h, got %0h", $time, what, want, got);
				errors++;
			end
		endfunction

		function void check_result(input rsp_t got);
			rsp_t want;
			if (awaited.size() == 0) begin
				if (errors < 40)
					$display("%0t unexpected result: expected none, got status %0d",
						$time, got.status);
				errors++;
				return;
			end
			want = awaited.pop_front();
			cmp("status", want.status, got.status);
			cmp("row_count", want.row_count, got.row_count);
			cmp("bad_row_count", want.bad_row_count, got.bad_row_count);
			cmp("bucket_count", want.bucket_count, got.bucket_count);
			cmp("multi_bucket_count", want.multi_bucket_count, got.multi_bucket_count);
			cmp("surplus_rows", want.surplus_rows, got.surplus_rows);
			cmp("pair_count", want.pair_count, got.pair_count);
			cmp("max_bucket", want.max_bucket, got.max_bucket);
			cmp("bin_count", want.bin_count, got.bin_count);
			checked++;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	collision_tally tally;
	logic [TAG_W-1:0] cur_tag;
	logic [LEN_W-1:0] cur_len;
	int sent = 0;
	int cyc = 0;
	int hold_left = 0;

	prefix_run_collision_stats u_top (
		.clk,
		.arst_n,
		.cfg_we,
		.cfg_index,
		.cfg_data,
		.req_valid,
		.req_ready,
		.req,
		.rsp_valid,
		.rsp_ready,
		.rsp
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cyc <= cyc + 1;
	end

	function automatic bit calm_window();
		return cyc >= 800 && cyc < 1500;
	endfunction

	function automatic logic [PFX_W-1:0] random_prefix();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[PFX_W-1:0];
	endfunction

	function automatic req_t noise_req();
		req_t q;
		q.req_type = REQ_W'($urandom_range(3));
		q.key_tag = TAG_W'($urandom_range(255));
		q.hash_prefix = random_prefix();
		q.key_length = LEN_W'($urandom_range(255));
		q.bin_index = BIN_W'($urandom_range(63));
		return q;
	endfunction

	function automatic req_t key_req(input logic [TAG_W-1:0] tag, input logic [PFX_W-1:0] pfx,
			input logic [LEN_W-1:0] len);
		req_t q;
		q = noise_req();
		q.req_type = REQ_KEY;
		q.key_tag = tag;
		q.hash_prefix = pfx;
		q.key_length = len;
		return q;
	endfunction

	function automatic req_t bin_req(input int idx);
		req_t q;
		q = noise_req();
		q.req_type = REQ_READ;
		q.bin_index = BIN_W'(idx);
		return q;
	endfunction

	function automatic req_t code_req(input logic [REQ_W-1:0] code);
		req_t q;
		q = noise_req();
		q.req_type = code;
		return q;
	endfunction

	function automatic int run_length();
		int p;
		p = $urandom_range(99);
		if (p < 70) return $urandom_range(3, 1);
		if (p < 92) return $urandom_range(12, 4);
		return $urandom_range(90, 55);
	endfunction

	task automatic send_req(input req_t q);
		if (!calm_window() && $urandom_range(99) < 10) begin
			req_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < 40);
		end
		req_valid <= 1'b1;
		req <= q;
		do @(posedge clk); while (!req_ready);
		tally.take_request(q);
		sent++;
		@(negedge clk);
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		while (tally.awaited.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_regs(input logic [TAG_W-1:0] tag, input logic [LEN_W-1:0] len);
		cfg_we <= 1'b1;
		cfg_index <= REG_ROW_TAG;
		cfg_data <= tag;
		@(negedge clk);
		cfg_index <= REG_KEY_LEN;
		cfg_data <= len;
		tally.set_reg(REG_ROW_TAG, tag);
		@(negedge clk);
		cfg_we <= 1'b0;
		tally.set_reg(REG_KEY_LEN, len);
		cur_tag = tag;
		cur_len = len;
	endtask

	task automatic scan_chunk(input int count);
		logic [PFX_W-1:0] pfx;
		logic [LEN_W-1:0] bad_len;
		int run_left;
		int pick;
		run_left = 0;
		pfx = '0;
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 6) begin
				send_req(bin_req($urandom_range(LAST_BIN)));
			end else if (pick < 8) begin
				send_req(code_req(REQ_UNUSED));
			end else if (pick < 14) begin
				bad_len = LEN_W'($urandom_range(255));
				if (bad_len == cur_len) bad_len = bad_len + 1'b1;
				send_req(key_req(cur_tag, random_prefix(), bad_len));
			end else begin
				if (run_left == 0) begin
					pfx = random_prefix();
					run_left = run_length();
				end
				send_req(key_req(cur_tag, pfx, cur_len));
				run_left--;
			end
		end
	endtask

	initial begin
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				rsp_ready <= 1'b0;
				hold_left--;
			end else begin
				rsp_ready <= calm_window() || $urandom_range(99) >= 10;
			end
			@(posedge clk);
			if (rsp_valid && rsp_ready) tally.check_result(rsp);
		end
	end

	initial begin
		req_t q;
		int b;
		tally = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_valid = 1'b0;
		req = '0;
		cur_tag = ROW_TAG_RST;
		cur_len = KEY_LEN_RST;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_req(bin_req(0));
		send_req(bin_req(LAST_BIN));
		q = '1;
		q.req_type = REQ_UNUSED;
		send_req(q);
		send_req(key_req(cur_tag, '0, '0));
		send_req(key_req(cur_tag, '1, '1));
		send_req(key_req(cur_tag, '0, cur_len));
		send_req(key_req(cur_tag, '0, cur_len));
		send_req(key_req(cur_tag, '0, cur_len - 1'b1));
		send_req(key_req(cur_tag, '0, cur_len));
		send_req(key_req(cur_tag, '1, cur_len));
		send_req(bin_req(3));
		send_req(key_req(cur_tag, '1, cur_len));
		send_req(code_req(REQ_UNUSED));
		send_req(key_req(cur_tag, {20{2'b01}}, cur_len));
		send_req(bin_req(3));
		send_req(bin_req(2));
		send_req(bin_req(1));
		send_req(key_req(cur_tag, {20{2'b10}}, cur_len));
		send_req(bin_req(1));

		scan_chunk(350);
		settle();
		write_regs(8'd0, 8'd1);
		scan_chunk(350);

		// stall the output while reads keep coming
		hold_left = 300;
		repeat (30) send_req(bin_req($urandom_range(LAST_BIN)));

		settle();
		write_regs(8'd255, 8'd255);
		scan_chunk(350);
		settle();
		write_regs(TAG_W'($urandom_range(255)), LEN_W'($urandom_range(255, 1)));
		scan_chunk(300);

		send_req(key_req(cur_tag + 8'd1, random_prefix(), cur_len));
		send_req(code_req(REQ_END));
		repeat (12) send_req(code_req(REQ_KEY));
		send_req(key_req(cur_tag, random_prefix(), cur_len));
		for (b = 0; b <= LAST_BIN; b++) send_req(bin_req(b));
		repeat (40) send_req(noise_req());
		send_req(code_req(REQ_END));

		req_valid <= 1'b0;
		while (tally.awaited.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);

		$display("sent %0d requests; checked %0d results (%0d bin reads, %0d totals reports)",
			sent, tally.checked, tally.bin_reads, tally.reports);
		$display("scan closed %0d buckets, largest %0d rows, %0d good and %0d malformed rows",
			tally.buckets, tally.largest, tally.rows, tally.malformed);
		if (tally.errors == 0 && tally.awaited.size() == 0) begin
			$display("prefix_run_collision_stats verification clean");
		end else begin
			$display("prefix_run_collision_stats verification failed");
		end
		$finish;
	end

	initial begin
		#1000000;
		$display("prefix_run_collision_stats verification failed");
		$finish;
	end

endmodule
